FILE: design/rct_pkg.sv
// Shared types and constants for the reference count table.
// Used by rct_ctrl, rct_dp and reference_count_table.
package rct_pkg;

	// Table geometry
	localparam int ENTRIES    = 16;
	localparam int COUNT_BITS = 16;
	localparam int KEY_BITS   = 48;
	localparam int IDX_BITS   = $clog2(ENTRIES);

	// Fixed field widths of the ports
	localparam int IN_KEY_BITS  = 48;
	localparam int OUT_CNT_BITS = 16;
	localparam int HANDLER_BITS = 8;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	// Command codes
	localparam logic [2:0] CMD_ADD     = 3'd0;
	localparam logic [2:0] CMD_INCR    = 3'd1;
	localparam logic [2:0] CMD_DECR    = 3'd2;
	localparam logic [2:0] CMD_CLAIM   = 3'd3;
	localparam logic [2:0] CMD_UNCLAIM = 3'd4;

	// Status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_UNAVAIL = 2'd1;
	localparam logic [1:0] ST_OWNER  = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	// One table entry as held in the entry memory
	typedef struct packed {
		logic [KEY_BITS-1:0]     key;
		logic [COUNT_BITS-1:0]   visits;
		logic [COUNT_BITS-1:0]   claims;
		logic [HANDLER_BITS-1:0] handler;
		logic [1:0]              flags;   // bit 0 free, bit 1 client
	} entry_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;   // latch request, restart scan
		logic scan;   // issue read of the next slot
		logic cmp;    // compare the slot read last cycle
		logic exec;   // apply command, write back, load result
	} ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic scan_last;   // scan index is at the last slot
	} sts_t;

endpackage

FILE: design/rct_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/rct_ctrl.sv
// Controller state machine for the reference count table.
// Depends on rct_pkg; drives the datapath rct_dp through ctl_t.
module rct_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	input  rct_pkg::sts_t sts,
	output rct_pkg::ctl_t ctl
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_LAST = 2'd2;
	localparam logic [1:0] S_EXEC = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					ctl.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				ctl.scan = 1'b1;
				ctl.cmp  = 1'b1;
				if (sts.scan_last) begin
					state_d = S_LAST;
				end
			end
			S_LAST: begin
				ctl.cmp = 1'b1;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				// wait until the result register is free or being taken
				if (!out_valid_q || !rsp_stall) begin
					ctl.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: design/rct_dp.sv
// Datapath of the reference count table: request latch, slot scan, entry memory,
// valid bits, command execution and result register. Depends on rct_pkg, rct_ram.
module rct_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rct_pkg::ctl_t                       ctl,
	output rct_pkg::sts_t                       sts,
	input  logic [2:0]                          cmd,
	input  logic [rct_pkg::IN_KEY_BITS-1:0]     key_addr,
	input  logic [rct_pkg::HANDLER_BITS-1:0]    handler_id,
	input  logic                                free_after,
	input  logic                                with_client,
	output logic [1:0]                          status,
	output logic [rct_pkg::OUT_CNT_BITS-1:0]    visits_now,
	output logic [rct_pkg::OUT_CNT_BITS-1:0]    claims_now,
	output logic                                released,
	output logic [rct_pkg::HANDLER_BITS-1:0]    released_handler,
	output logic                                released_free,
	output logic                                released_client
);

	localparam int EW = $bits(rct_pkg::entry_t);

	// request latch
	logic [2:0]                        cmd_q;
	logic [rct_pkg::KEY_BITS-1:0]      key_q;
	logic [rct_pkg::HANDLER_BITS-1:0]  hid_q;
	logic [1:0]                        flg_q;

	// scan state
	logic [rct_pkg::IDX_BITS-1:0]      idx_q;
	logic                              pend_q;
	logic [rct_pkg::IDX_BITS-1:0]      pend_idx_q;
	logic                              hit_q;
	logic [rct_pkg::IDX_BITS-1:0]      hit_idx_q;
	rct_pkg::entry_t                   ent_q;
	logic                              free_q;
	logic [rct_pkg::IDX_BITS-1:0]      free_idx_q;
	logic [rct_pkg::ENTRIES-1:0]       valid_q;

	// memory signals
	logic                              mem_we;
	logic [rct_pkg::IDX_BITS-1:0]      mem_waddr;
	rct_pkg::entry_t                   mem_wentry;
	logic [EW-1:0]                     mem_rdata;
	rct_pkg::entry_t                   rd_ent;

	// execution results
	logic [rct_pkg::COUNT_BITS-1:0]    nv;
	logic [rct_pkg::COUNT_BITS-1:0]    nc;
	logic [1:0]                        st;
	logic                              rel;
	logic                              show;
	logic                              wr;
	logic                              set_v;
	logic                              do_inc;
	logic                              do_dec;
	logic [rct_pkg::IDX_BITS-1:0]      wslot;
	logic [63:0]                       key_ext;
	logic [31:0]                       nv_ext;
	logic [31:0]                       nc_ext;

	assign key_ext       = 64'(key_addr);
	assign rd_ent        = rct_pkg::entry_t'(mem_rdata);
	assign sts.scan_last = (idx_q == rct_pkg::IDX_BITS'(rct_pkg::ENTRIES - 1));

	rct_ram #(
		.WIDTH(EW),
		.DEPTH(rct_pkg::ENTRIES)
	) u_entries (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wentry),
		.re   (ctl.scan),
		.raddr(idx_q),
		.rdata(mem_rdata)
	);

	// request latch and slot scan
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= cmd;
			key_q  <= key_ext[rct_pkg::KEY_BITS-1:0];
			hid_q  <= handler_id;
			flg_q  <= {with_client, free_after};
			idx_q  <= '0;
			pend_q <= 1'b0;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else begin
			if (ctl.scan) begin
				idx_q      <= idx_q + 1'b1;
				pend_q     <= 1'b1;
				pend_idx_q <= idx_q;
			end
			// first matching slot and first free slot
			if (ctl.cmp && pend_q) begin
				if (valid_q[pend_idx_q] && rd_ent.key == key_q && !hit_q) begin
					hit_q     <= 1'b1;
					hit_idx_q <= pend_idx_q;
					ent_q     <= rd_ent;
				end
				if (!valid_q[pend_idx_q] && !free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= pend_idx_q;
				end
			end
		end
	end

	// command execution
	always_comb begin
		nv     = ent_q.visits;
		nc     = ent_q.claims;
		st     = rct_pkg::ST_UNAVAIL;
		rel    = 1'b0;
		show   = 1'b0;
		wr     = 1'b0;
		set_v  = 1'b0;
		do_inc = 1'b0;
		do_dec = 1'b0;
		wslot  = hit_idx_q;
		case (cmd_q)
			rct_pkg::CMD_ADD: begin
				if (hit_q || free_q) begin
					wslot = hit_q ? hit_idx_q : free_idx_q;
					nv    = rct_pkg::COUNT_BITS'(1);
					nc    = '0;
					st    = rct_pkg::ST_OK;
					wr    = 1'b1;
					set_v = 1'b1;
					show  = 1'b1;
				end else begin
					st = rct_pkg::ST_FULL;
				end
			end
			rct_pkg::CMD_INCR: begin
				do_inc = hit_q;
			end
			rct_pkg::CMD_DECR: begin
				do_dec = hit_q;
			end
			rct_pkg::CMD_CLAIM: begin
				if (hit_q) begin
					if (nc != rct_pkg::CNT_MAX) begin
						nc = nc + 1'b1;
					end
					do_inc = 1'b1;
				end
			end
			rct_pkg::CMD_UNCLAIM: begin
				if (hit_q) begin
					show = 1'b1;
					if (nc != '0) begin
						nc     = nc - 1'b1;
						do_dec = 1'b1;
					end
				end
			end
			default: begin
				st = rct_pkg::ST_UNAVAIL;
			end
		endcase

		// visit increment, saturating
		if (do_inc) begin
			show = 1'b1;
			wr   = 1'b1;
			if (nv == rct_pkg::CNT_MAX) begin
				st = rct_pkg::ST_UNAVAIL;
			end else begin
				nv = nv + 1'b1;
				st = rct_pkg::ST_OK;
			end
		end

		// visit decrement; deletes an emptied unclaimed entry
		if (do_dec) begin
			show = 1'b1;
			wr   = 1'b1;
			if (nv < nc) begin
				st = rct_pkg::ST_UNAVAIL;
			end else if (nv > rct_pkg::COUNT_BITS'(1)) begin
				nv = nv - 1'b1;
				st = rct_pkg::ST_OK;
			end else if (nc != '0) begin
				st = rct_pkg::ST_OWNER;
			end else begin
				rel = 1'b1;
				st  = rct_pkg::ST_OK;
			end
		end
	end

	// write-back
	assign mem_we    = ctl.exec && wr;
	assign mem_waddr = wslot;
	always_comb begin
		if (cmd_q == rct_pkg::CMD_ADD) begin
			mem_wentry.key     = key_q;
			mem_wentry.handler = hid_q;
			mem_wentry.flags   = flg_q;
		end else begin
			mem_wentry.key     = ent_q.key;
			mem_wentry.handler = ent_q.handler;
			mem_wentry.flags   = ent_q.flags;
		end
		mem_wentry.visits = nv;
		mem_wentry.claims = nc;
	end

	// slot valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.exec) begin
			if (set_v) begin
				valid_q[wslot] <= 1'b1;
			end else if (rel) begin
				valid_q[wslot] <= 1'b0;
			end
		end
	end

	// result register
	assign nv_ext = 32'(nv);
	assign nc_ext = 32'(nc);
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			status <= st;
			if (show && !rel) begin
				visits_now <= nv_ext[rct_pkg::OUT_CNT_BITS-1:0];
				claims_now <= nc_ext[rct_pkg::OUT_CNT_BITS-1:0];
			end else begin
				visits_now <= '0;
				claims_now <= '0;
			end
			released         <= rel;
			released_handler <= rel ? ent_q.handler : '0;
			released_free    <= rel & ent_q.flags[0];
			released_client  <= rel & ent_q.flags[1];
		end
	end

endmodule

FILE: design/reference_count_table.sv
// Top level of the reference count table: controller plus datapath.
// Depends on rct_pkg, rct_ctrl, rct_dp (which holds the rct_ram entry memory).
//
//   channel   valid       stall       payload
//   request   req_valid   req_stall   cmd, key_addr, handler_id, free_after, with_client
//   result    rsp_valid   rsp_stall   status, visits_now, claims_now, released,
//                                     released_handler, released_free, released_client
//
// The key scan reads the entry memory one slot per cycle, then a last step
// finishes the final compare and an execute step applies the command and loads
// the result register. A new request is taken only after the execute step.
// Reset clears the slot valid bits at once; no clearing pass is needed.
// The result register holds while rsp_stall is high; a new request is taken
// meanwhile, and it waits only at its execute step until the old result leaves.
module reference_count_table (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  logic [2:0]                       cmd,
	input  logic [rct_pkg::IN_KEY_BITS-1:0]  key_addr,
	input  logic [rct_pkg::HANDLER_BITS-1:0] handler_id,
	input  logic                             free_after,
	input  logic                             with_client,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output logic [1:0]                       status,
	output logic [rct_pkg::OUT_CNT_BITS-1:0] visits_now,
	output logic [rct_pkg::OUT_CNT_BITS-1:0] claims_now,
	output logic                             released,
	output logic [rct_pkg::HANDLER_BITS-1:0] released_handler,
	output logic                             released_free,
	output logic                             released_client
);

	rct_pkg::ctl_t ctl;
	rct_pkg::sts_t sts;

	rct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	rct_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.sts             (sts),
		.cmd             (cmd),
		.key_addr        (key_addr),
		.handler_id      (handler_id),
		.free_after      (free_after),
		.with_client     (with_client),
		.status          (status),
		.visits_now      (visits_now),
		.claims_now      (claims_now),
		.released        (released),
		.released_handler(released_handler),
		.released_free   (released_free),
		.released_client (released_client)
	);

endmodule
